// ===== src/rlcum_pkg.sv =====
package rlcum_pkg;

  localparam int unsigned FLOWS_DEF    = 32;
  localparam int unsigned SEQ_BITS_DEF = 16;

  localparam int unsigned FLOW_W = 5;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned NUM_W  = 16;
  localparam int unsigned SEG_W  = 8;
  localparam int unsigned VERD_W = 3;

  typedef enum logic [VERD_W-1:0] {
    V_DELIVER    = 3'd0,
    V_DROP_ADDR  = 3'd1,
    V_NOT_DATA   = 3'd2,
    V_CONSUMED   = 3'd3,
    V_INCOMPLETE = 3'd4
  } verdict_t;

  typedef struct packed {
    logic     wr;
    verdict_t verdict;
  } upd_ctl_t;

endpackage

// ===== src/rlc_um_rx_sdu_completeness_check.sv =====
// Receive-side SDU completeness check for an unacknowledged-mode link layer.
// Each input beat is one PDU descriptor and yields exactly one verdict beat.
// Each PDU first has its flow's entry read from the flow table memory and is
// then judged and the entry written back; a new PDU is taken once the
// previous one has left the table, and a verdict still waiting on the
// output holds the judging step. The flow table needs no clearing pass
// after reset: a valid bit per flow makes an unwritten entry read as zero.
// own_address may only be written while no PDU is in flight.
module rlc_um_rx_sdu_completeness_check #(
  parameter int unsigned FLOWS    = rlcum_pkg::FLOWS_DEF,
  parameter int unsigned SEQ_BITS = rlcum_pkg::SEQ_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rlcum_pkg::ADDR_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rlcum_pkg::FLOW_W-1:0] flow_id,
  input  logic [rlcum_pkg::ADDR_W-1:0] dest_addr,
  input  logic                         pdu_error,
  input  logic                         is_data,
  input  logic [rlcum_pkg::NUM_W-1:0]  pdu_seqno,
  input  logic [rlcum_pkg::NUM_W-1:0]  eop_seqno,
  input  logic [rlcum_pkg::NUM_W-1:0]  sdu_number,
  input  logic [rlcum_pkg::SEG_W-1:0]  segment_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rlcum_pkg::VERD_W-1:0] verdict
);

  import rlcum_pkg::*;

  localparam int unsigned FIDX = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int unsigned EW   = SEQ_BITS + NUM_W + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0]   own_address;
  logic [FLOW_W-1:0]   flow_q;
  logic [ADDR_W-1:0]   dest_q;
  logic                err_q;
  logic                data_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [SEQ_BITS-1:0] eop_q;
  logic [NUM_W-1:0]    sdu_q;
  logic [SEG_W-1:0]    seg_q;
  logic [FLOWS-1:0]    entry_vld;
  verdict_t            verdict_q;

  logic                in_accept;
  logic                in_range_in;
  logic                in_range_q;
  logic                done;
  logic [FIDX-1:0]     addr_q;
  logic [EW-1:0]       rd_data;
  logic [EW-1:0]       entry;
  logic [EW-1:0]       wr_data;
  upd_ctl_t            ctl;
  logic [SEQ_BITS-1:0] new_seq;
  logic [NUM_W-1:0]    new_sdu;
  logic                new_dmg;

  assign in_ready    = (state == S_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign in_range_in = (32'(flow_id) < 32'(FLOWS));
  assign in_range_q  = (32'(flow_q) < 32'(FLOWS));
  assign addr_q      = FIDX'(flow_q);
  assign done        = (state == S_LOOK) && (!out_valid || out_ready);

  rlcum_ram #(
    .WIDTH (EW),
    .DEPTH (FLOWS)
  ) u_flow_tab (
    .clk     (clk),
    .wr_en   (done && ctl.wr),
    .wr_addr (addr_q),
    .wr_data (wr_data),
    .rd_en   (in_accept && in_range_in),
    .rd_addr (FIDX'(flow_id)),
    .rd_data (rd_data)
  );

  // An entry that was never written reads as all zero.
  assign entry   = (in_range_q && entry_vld[addr_q]) ? rd_data : '0;
  assign wr_data = {new_seq, new_sdu, new_dmg};

  rlcum_flow_upd #(
    .SEQ_BITS (SEQ_BITS)
  ) u_upd (
    .own_address   (own_address),
    .dest_addr     (dest_q),
    .pdu_error     (err_q),
    .is_data       (data_q),
    .in_range      (in_range_q),
    .seq           (seq_q),
    .eop           (eop_q),
    .sdu_number    (sdu_q),
    .segment_index (seg_q),
    .cur_seq       (entry[EW-1 -: SEQ_BITS]),
    .cur_sdu       (entry[NUM_W:1]),
    .cur_dmg       (entry[0]),
    .ctl           (ctl),
    .new_seq       (new_seq),
    .new_sdu       (new_sdu),
    .new_dmg       (new_dmg)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      own_address <= '0;
      entry_vld   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        own_address <= cfg_wr_data;
      end
      if (done && ctl.wr) begin
        entry_vld[addr_q] <= 1'b1;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      flow_q <= flow_id;
      dest_q <= dest_addr;
      err_q  <= pdu_error;
      data_q <= is_data;
      seq_q  <= SEQ_BITS'(pdu_seqno);
      eop_q  <= SEQ_BITS'(eop_seqno);
      sdu_q  <= sdu_number;
      seg_q  <= segment_index;
    end
    if (done) begin
      verdict_q <= ctl.verdict;
    end
  end

  assign verdict = verdict_q;

endmodule

// ===== src/rlcum_ram.sv =====
module rlcum_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/rlcum_flow_upd.sv =====
module rlcum_flow_upd #(
  parameter int unsigned SEQ_BITS = rlcum_pkg::SEQ_BITS_DEF
) (
  input  logic [rlcum_pkg::ADDR_W-1:0] own_address,
  input  logic [rlcum_pkg::ADDR_W-1:0] dest_addr,
  input  logic                         pdu_error,
  input  logic                         is_data,
  input  logic                         in_range,
  input  logic [SEQ_BITS-1:0]          seq,
  input  logic [SEQ_BITS-1:0]          eop,
  input  logic [rlcum_pkg::NUM_W-1:0]  sdu_number,
  input  logic [rlcum_pkg::SEG_W-1:0]  segment_index,
  input  logic [SEQ_BITS-1:0]          cur_seq,
  input  logic [rlcum_pkg::NUM_W-1:0]  cur_sdu,
  input  logic                         cur_dmg,
  output rlcum_pkg::upd_ctl_t          ctl,
  output logic [SEQ_BITS-1:0]          new_seq,
  output logic [rlcum_pkg::NUM_W-1:0]  new_sdu,
  output logic                         new_dmg
);

  import rlcum_pkg::*;

  logic in_order;

  assign in_order = (cur_seq == seq);

  always_comb begin
    ctl.wr      = 1'b0;
    ctl.verdict = V_CONSUMED;
    new_seq     = seq + SEQ_BITS'(1);
    new_sdu     = cur_sdu;
    new_dmg     = cur_dmg;
    priority if (dest_addr != own_address || pdu_error) begin
      ctl.verdict = V_DROP_ADDR;
    end else if (!is_data) begin
      ctl.verdict = V_NOT_DATA;
    end else if (!in_range) begin
      ctl.verdict = V_DROP_ADDR;
    end else if (seq == eop) begin
      // The last PDU closes the SDU whatever its fate.
      ctl.wr      = 1'b1;
      ctl.verdict = (in_order && cur_sdu == sdu_number && !cur_dmg) ?
                    V_DELIVER : V_INCOMPLETE;
      new_sdu     = sdu_number + NUM_W'(1);
      new_dmg     = 1'b0;
    end else begin
      ctl.wr = 1'b1;
      if (!in_order) begin
        // A gap inside an SDU damages it; a gap before its first segment does not.
        new_sdu = sdu_number;
        if (segment_index != '0) begin
          new_dmg = 1'b1;
        end
      end
    end
  end

endmodule
